/* sv/acvp_pkg.sv */
// Shared types and constants for the ASCII command/value parser.
// No dependencies; every other file but acvp_in_if imports this package.
package acvp_pkg;

    localparam int VALUE_W  = 23;
    localparam int NUM_TAPS = 6;
    localparam int LEN_W    = 4;

    localparam logic [7:0] CHAR_BANG  = 8'h21;
    localparam logic [7:0] CHAR_EQ    = 8'h3D;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] DIGIT_BIAS = 8'd48;

    // A leading minus can negate the largest value, so the floor mirrors the top.
    localparam logic signed [VALUE_W-1:0] VALUE_MIN = -23'sd2299977;
    localparam logic signed [VALUE_W-1:0] VALUE_MAX = 23'sd2299977;

    typedef enum logic [1:0] {
        FORM_NONE,
        FORM_D_DD,
        FORM_DD_DD,
        FORM_DDD_DD
    } t_form;

    // One finished line: taps hold the last characters, tap 0 the newest.
    typedef struct packed {
        logic [7:0]                cmd;
        logic                      neg;
        t_form                     form;
        logic [NUM_TAPS-1:0][7:0]  taps;
    } t_job;

    function automatic logic signed [VALUE_W-1:0] to_digit(input logic [7:0] ch);
        return $signed({{(VALUE_W-8){1'b0}}, ch}) - $signed({{(VALUE_W-8){1'b0}}, DIGIT_BIAS});
    endfunction

endpackage

/* sv/acvp_in_if.sv */
// Byte input channel of the parser: valid/ready handshake plus one byte.
// Depends on no other file.
interface acvp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

/* sv/acvp_out_if.sv */
// Result channel of the parser: command byte and signed value in hundredths.
// Depends on acvp_pkg for the value width.
interface acvp_out_if;
    import acvp_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [7:0]                command_byte;
    logic signed [VALUE_W-1:0] value_hundredths;

    modport source (output valid, output command_byte, output value_hundredths, input ready);
    modport sink   (input valid, input command_byte, input value_hundredths, output ready);
endinterface

/* sv/acvp_front.sv */
// Front end: takes bytes, tracks the line and the value characters, and
// pushes one job per finished line. Depends on acvp_pkg and acvp_in_if.
module acvp_front #(
    parameter int SCAN_LEN = 10
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    acvp_in_if.sink          i_in,
    input  logic             i_q_full,
    output logic             o_push,
    output acvp_pkg::t_job   o_job
);
    import acvp_pkg::*;

    localparam int CNT_W = $clog2(SCAN_LEN + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(SCAN_LEN);
    localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

    logic [CNT_W-1:0]          r_count, n_count;
    logic [7:0]                r_cmd, n_cmd;
    logic [LEN_W-1:0]          r_len, n_len;
    logic                      r_minus, n_minus;
    logic [NUM_TAPS-1:0][7:0]  r_taps, n_taps;

    logic                      accept;
    logic [7:0]                b;
    logic [LEN_W-1:0]          n_chars;

    assign i_in.ready = !i_q_full;
    assign accept     = i_in.valid && i_in.ready;
    assign b          = i_in.rx_byte;

    // Value length without the sign.
    assign n_chars = r_len - LEN_W'(r_minus);

    always_comb begin
        o_job.cmd  = r_cmd;
        o_job.neg  = r_minus;
        o_job.taps = r_taps;
        o_job.form = FORM_NONE;
        if (r_count < CNT_MAX) begin
            case (n_chars)
                LEN_W'(4): o_job.form = FORM_D_DD;
                LEN_W'(5): o_job.form = FORM_DD_DD;
                LEN_W'(6): o_job.form = FORM_DDD_DD;
                default:   o_job.form = FORM_NONE;
            endcase
        end
    end

    assign o_push = accept && (r_count != '0) && (b == CHAR_BANG);

    always_comb begin
        n_count = r_count;
        n_cmd   = r_cmd;
        n_len   = r_len;
        n_minus = r_minus;
        n_taps  = r_taps;
        if (accept) begin
            if (r_count == '0) begin
                // Command byte; position 0 of the line reads as a zero byte.
                n_cmd   = b;
                n_count = CNT_W'(1);
                n_len   = LEN_W'(1);
                n_minus = 1'b0;
                n_taps  = {r_taps[NUM_TAPS-2:0], 8'h00};
            end else if (b == CHAR_BANG) begin
                n_count = '0;
            end else if (r_count < CNT_MAX) begin
                n_count = r_count + CNT_W'(1);
                if (b == CHAR_EQ) begin
                    n_len   = '0;
                    n_minus = 1'b0;
                end else begin
                    if ((r_len == '0) && (b == CHAR_MINUS)) begin
                        n_minus = 1'b1;
                    end
                    if (r_len != LEN_MAX) begin
                        n_len = r_len + LEN_W'(1);
                    end
                    n_taps = {r_taps[NUM_TAPS-2:0], b};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_cmd   <= '0;
            r_len   <= '0;
            r_minus <= 1'b0;
        end else begin
            r_count <= n_count;
            r_cmd   <= n_cmd;
            r_len   <= n_len;
            r_minus <= n_minus;
        end
        r_taps <= n_taps;
    end

endmodule

/* sv/acvp_queue.sv */
// Two-entry job queue between front and back end.
// Depends on acvp_pkg.
module acvp_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  acvp_pkg::t_job i_job,
    output logic           o_full,
    output logic           o_valid,
    output acvp_pkg::t_job o_job,
    input  logic           i_pop
);
    import acvp_pkg::*;

    localparam int DEPTH  = 2;
    localparam int PTR_W  = $clog2(DEPTH);
    localparam int FILL_W = $clog2(DEPTH + 1);

    t_job              r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [FILL_W-1:0] r_fill;
    logic              push_en, pop_en;

    assign o_full  = (r_fill == FILL_W'(DEPTH));
    assign o_valid = (r_fill != '0);
    assign o_job   = r_mem[r_rd_ptr];
    assign push_en = i_push && !o_full;
    assign pop_en  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (push_en) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (push_en) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (pop_en) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            case ({push_en, pop_en})
                2'b10:   r_fill <= r_fill + FILL_W'(1);
                2'b01:   r_fill <= r_fill - FILL_W'(1);
                default: r_fill <= r_fill;
            endcase
        end
    end

endmodule

/* sv/acvp_back.sv */
// Back end: weights the value characters, sums them and holds the result
// in the output register. Depends on acvp_pkg and acvp_out_if.
module acvp_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_job_valid,
    input  acvp_pkg::t_job i_job,
    output logic           o_pop,
    acvp_out_if.source     o_out
);
    import acvp_pkg::*;

    localparam int NUM_TERMS = 5;

    logic                                      r_a_valid;
    logic [7:0]                                r_a_cmd;
    logic                                      r_a_neg;
    logic signed [NUM_TERMS-1:0][VALUE_W-1:0]  r_a_terms, n_a_terms;

    logic                      r_o_valid;
    logic [7:0]                r_o_cmd;
    logic signed [VALUE_W-1:0] r_o_value, n_o_value;

    logic load_out, a_ready;

    assign load_out = r_a_valid && (!r_o_valid || o_out.ready);
    assign a_ready  = !r_a_valid || load_out;
    assign o_pop    = i_job_valid && a_ready;

    // Weight each tap; the tap in the decimal point place is skipped.
    always_comb begin
        n_a_terms = '0;
        if (i_job.form != FORM_NONE) begin
            n_a_terms[0] = to_digit(i_job.taps[0]);
            n_a_terms[1] = to_digit(i_job.taps[1]) * 23'sd10;
            n_a_terms[2] = to_digit(i_job.taps[3]) * 23'sd100;
        end
        if ((i_job.form == FORM_DD_DD) || (i_job.form == FORM_DDD_DD)) begin
            n_a_terms[3] = to_digit(i_job.taps[4]) * 23'sd1000;
        end
        if (i_job.form == FORM_DDD_DD) begin
            n_a_terms[4] = to_digit(i_job.taps[5]) * 23'sd10000;
        end
    end

    always_comb begin
        logic signed [VALUE_W-1:0] sum;
        sum = r_a_terms[0] + r_a_terms[1] + r_a_terms[2] + r_a_terms[3] + r_a_terms[4];
        n_o_value = r_a_neg ? -sum : sum;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (a_ready) begin
                r_a_valid <= i_job_valid;
            end
            if (load_out) begin
                r_o_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_o_valid <= 1'b0;
            end
        end
        if (o_pop) begin
            r_a_cmd   <= i_job.cmd;
            r_a_neg   <= i_job.neg;
            r_a_terms <= n_a_terms;
        end
        if (load_out) begin
            r_o_cmd   <= r_a_cmd;
            r_o_value <= n_o_value;
        end
    end

    assign o_out.valid            = r_o_valid;
    assign o_out.command_byte     = r_o_cmd;
    assign o_out.value_hundredths = r_o_value;

endmodule

/* sv/ascii_command_value_parser_top.sv */
// Top level of the ASCII command/value parser.
// Depends on acvp_pkg, acvp_in_if, acvp_out_if, acvp_front, acvp_queue, acvp_back.
//
//  Channel   Direction  Word                              Handshake
//  i_in      in         rx_byte[7:0]                      valid/ready
//  o_out     out        command_byte[7:0],                valid/ready
//                       value_hundredths[22:0] signed
//
// One byte is taken every cycle while the job queue has room; the queue only
// fills when the result side holds off ready.
// Once the '!' that ends its line is taken, a result passes through the queue,
// the weighting stage and the summing stage, each of them registered.
// Reset is synchronous and active low; it empties the queue and the pipeline
// and starts a fresh line. The line state needs no clearing pass.
// Stalls on the output side back up through the queue into i_in.ready.
module ascii_command_value_parser_top #(
    parameter int SCAN_LEN = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    acvp_in_if.sink     i_in,
    acvp_out_if.source  o_out
);
    import acvp_pkg::*;

    // Jobs from the front end into the queue
    logic  push;
    t_job  push_job;
    logic  q_full;

    // Jobs from the queue into the back end
    logic  q_valid;
    t_job  q_job;
    logic  pop;

    // Classify bytes, track the value characters, push finished lines
    acvp_front #(
        .SCAN_LEN (SCAN_LEN)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_q_full (q_full),
        .o_push   (push),
        .o_job    (push_job)
    );

    // Hold finished lines while the back end is busy
    acvp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_job   (q_job),
        .i_pop   (pop)
    );

    // Compute the value and present the result word
    acvp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (q_valid),
        .i_job       (q_job),
        .o_pop       (pop),
        .o_out       (o_out)
    );

endmodule

/* sv/acvp_checker.sv */
// Port-level checks for the parser top level, bound onto it.
// Depends on acvp_pkg and ascii_command_value_parser_top.
module acvp_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_in_valid,
    input logic                               i_in_ready,
    input logic                               i_out_valid,
    input logic                               i_out_ready,
    input logic [7:0]                         i_out_cmd,
    input logic signed [acvp_pkg::VALUE_W-1:0] i_out_value
);
    import acvp_pkg::*;

    // Value stays inside what any byte mix can give
    a_value_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> ((i_out_value >= VALUE_MIN) && (i_out_value <= VALUE_MAX)))
        else $error("result value out of range");

    // Reset drops the output word
    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    // Empty queue after reset: input side ready at once
    a_reset_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> i_in_ready)
        else $error("input not ready after reset");

    // Stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_out_cmd) && $stable(i_out_value)))
        else $error("stalled result changed");

endmodule

bind ascii_command_value_parser_top acvp_checker u_acvp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_cmd   (o_out.command_byte),
    .i_out_value (o_out.value_hundredths)
);
